[hw/rtl/tpc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared types and constants for the transpose priority cache.
// ----------------------------------------------------------------------------
package tpc_pkg;

    // Field widths
    localparam int OP_W  = 2;
    localparam int KEY_W = 32;
    localparam int VAL_W = 64;
    localparam int POS_W = 4;
    localparam int CAP_W = 5;

    // Capacity after reset, before clamping to the table size
    localparam int CAPACITY_RESET = 16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    // Key returned when nothing is found
    localparam logic [KEY_W-1:0] KEY_NOT_FOUND = {KEY_W{1'b1}};

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_UPDATE
    } tpc_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the incoming transaction
        logic compare;   // compare key against all entries, register match vector
        logic commit;    // apply state update and load the result register
    } tpc_cmd_t;

endpackage

[hw/rtl/tpc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_ctrl
// Sequencer for the cache: capture, compare, update, and the result valid flag.
// ----------------------------------------------------------------------------
module tpc_ctrl
    import tpc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output tpc_cmd_t cmd
);

    tpc_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    // Result register can take a new transaction when empty or being drained
    assign out_free = !m_valid_reg || m_ready;

    // State and valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        cmd.capture = 1'b0;
        cmd.compare = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_COMPARE;
                end
            end
            ST_COMPARE: begin
                cmd.compare = 1'b1;
                state_next  = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (out_free) begin
                    cmd.commit = 1'b1;
                    s_ready    = 1'b1;
                    if (s_valid) begin
                        cmd.capture = 1'b1;
                        state_next  = ST_COMPARE;
                    end else begin
                        state_next  = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Result valid flag
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    // A commit never overwrites a result that is still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid_reg || m_ready))
        else $error("tpc_ctrl: result overwritten");

    // A captured transaction is compared in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> (state_reg == ST_COMPARE))
        else $error("tpc_ctrl: capture not followed by compare");

    // Compare is always followed by the update step
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.compare |=> (state_reg == ST_UPDATE))
        else $error("tpc_ctrl: compare not followed by update");

    // Result valid only rises after a commit
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.commit))
        else $error("tpc_ctrl: result valid without commit");
`endif

endmodule

[hw/rtl/tpc_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_datapath
// Entry row, fill count, capacity, last hit key, compare and result registers.
// ----------------------------------------------------------------------------
module tpc_datapath
    import tpc_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  logic              aclk,
    input  logic              aresetn,
    input  tpc_cmd_t          cmd,
    input  logic [OP_W-1:0]   s_op,
    input  logic [KEY_W-1:0]  s_key,
    input  logic [VAL_W-1:0]  s_value_in,
    input  logic [POS_W-1:0]  s_position,
    input  logic              cfg_write,
    input  logic [CAP_W-1:0]  cfg_capacity_in_use,
    output logic              m_found,
    output logic [VAL_W-1:0]  m_value_out,
    output logic [KEY_W-1:0]  m_key_out
);

    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int CAP_RST = (CAPACITY_RESET > MAX_ENTRIES) ? MAX_ENTRIES : CAPACITY_RESET;

    // Entry row
    logic [KEY_W-1:0] keys_reg   [MAX_ENTRIES];
    logic [KEY_W-1:0] keys_next  [MAX_ENTRIES];
    logic [VAL_W-1:0] vals_reg   [MAX_ENTRIES];
    logic [VAL_W-1:0] vals_next  [MAX_ENTRIES];
    logic             entry_we;

    // Control state
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] cap_reg, cap_next;
    logic [KEY_W-1:0] last_hit_reg, last_hit_next;

    // Captured transaction
    logic [OP_W-1:0]  op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;
    logic [POS_W-1:0] pos_reg;

    // Match vector from the compare step
    logic [MAX_ENTRIES-1:0] match_reg, match_next;
    logic [MAX_ENTRIES-1:0] first_hit;

    // Result register
    logic             found_reg, found_next;
    logic [VAL_W-1:0] value_out_reg, value_out_next;
    logic [KEY_W-1:0] key_out_reg, key_out_next;

    // Update step signals
    logic             hit;
    logic             seen;
    logic             do_swap;
    logic             do_insert;
    logic             rd_ok;
    logic [VAL_W-1:0] hit_value;
    logic [KEY_W-1:0] rd_key;
    logic [CNT_W-1:0] ins_fill;

    // Capture the incoming transaction
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= s_op;
            key_reg   <= s_key;
            value_reg <= s_value_in;
            pos_reg   <= s_position;
        end
    end

    // Parallel compare across the filled entries
    always_comb begin
        for (int j = 0; j < MAX_ENTRIES; j++) begin
            match_next[j] = (keys_reg[j] == key_reg) && (CNT_W'(j) < fill_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.compare) begin
            match_reg <= match_next;
        end
    end

    // First hit from the front, as a one-hot vector, and its value
    always_comb begin
        seen      = 1'b0;
        hit_value = '0;
        for (int j = 0; j < MAX_ENTRIES; j++) begin
            first_hit[j] = match_reg[j] && !seen;
            seen         = seen || match_reg[j];
            if (first_hit[j]) begin
                hit_value = vals_reg[j];
            end
        end
        hit = seen;
    end

    // Position read
    always_comb begin
        rd_key = '0;
        for (int j = 0; j < MAX_ENTRIES; j++) begin
            if (CMP_W'(pos_reg) == CMP_W'(j)) begin
                rd_key = keys_reg[j];
            end
        end
        rd_ok = (CMP_W'(pos_reg) < CMP_W'(cap_reg)) && (CMP_W'(pos_reg) < CMP_W'(fill_reg));
    end

    // Update decisions
    assign do_insert = cmd.commit && (op_reg == OP_INSERT);
    assign do_swap   = cmd.commit && (op_reg == OP_LOOKUP) && hit
                       && (last_hit_reg == key_reg) && !first_hit[0];
    assign ins_fill  = (fill_reg < cap_reg) ? fill_reg + CNT_W'(1) : fill_reg;
    assign entry_we  = do_insert || do_swap;

    // Next entry row: shift on insert, transpose with predecessor on repeat hit
    always_comb begin
        for (int j = 0; j < MAX_ENTRIES; j++) begin
            keys_next[j] = keys_reg[j];
            vals_next[j] = vals_reg[j];
        end
        if (do_insert) begin
            keys_next[0] = key_reg;
            vals_next[0] = value_reg;
            for (int j = 1; j < MAX_ENTRIES; j++) begin
                keys_next[j] = keys_reg[j-1];
                vals_next[j] = vals_reg[j-1];
            end
        end else if (do_swap) begin
            for (int j = 1; j < MAX_ENTRIES; j++) begin
                if (first_hit[j]) begin
                    keys_next[j] = keys_reg[j-1];
                    vals_next[j] = vals_reg[j-1];
                end
            end
            for (int j = 0; j < MAX_ENTRIES - 1; j++) begin
                if (first_hit[j+1]) begin
                    keys_next[j] = keys_reg[j+1];
                    vals_next[j] = vals_reg[j+1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (entry_we) begin
            for (int j = 0; j < MAX_ENTRIES; j++) begin
                keys_reg[j] <= keys_next[j];
                vals_reg[j] <= vals_next[j];
            end
        end
    end

    // Fill count, capacity and last hit key
    always_comb begin
        fill_next     = fill_reg;
        cap_next      = cap_reg;
        last_hit_next = last_hit_reg;
        if (cfg_write && (cfg_capacity_in_use != '0)) begin
            if (CMP_W'(cfg_capacity_in_use) > CMP_W'(MAX_ENTRIES)) begin
                cap_next = CNT_W'(MAX_ENTRIES);
            end else begin
                cap_next = CNT_W'(cfg_capacity_in_use);
            end
            fill_next = '0;
        end else if (do_insert) begin
            fill_next = ins_fill;
        end
        if (cmd.commit && (op_reg == OP_LOOKUP) && hit) begin
            last_hit_next = key_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            cap_reg      <= CNT_W'(CAP_RST);
            last_hit_reg <= '0;
        end else begin
            fill_reg     <= fill_next;
            cap_reg      <= cap_next;
            last_hit_reg <= last_hit_next;
        end
    end

    // Result for the current transaction
    always_comb begin
        found_next     = 1'b0;
        value_out_next = '0;
        key_out_next   = KEY_NOT_FOUND;
        case (op_reg)
            OP_LOOKUP: begin
                if (hit) begin
                    found_next     = 1'b1;
                    value_out_next = hit_value;
                    key_out_next   = key_reg;
                end
            end
            OP_READ: begin
                if (rd_ok) begin
                    found_next   = 1'b1;
                    key_out_next = rd_key;
                end
            end
            default: begin
                found_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            found_reg     <= found_next;
            value_out_reg <= value_out_next;
            key_out_reg   <= key_out_next;
        end
    end

    assign m_found     = found_reg;
    assign m_value_out = value_out_reg;
    assign m_key_out   = key_out_reg;

`ifndef SYNTHESIS
    // Fill never exceeds the capacity in use
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= cap_reg)
        else $error("tpc_datapath: fill above capacity");

    // Capacity stays within one and the table size
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cap_reg != '0) && (CMP_W'(cap_reg) <= CMP_W'(MAX_ENTRIES)))
        else $error("tpc_datapath: capacity out of range");

    // An insert without a capacity write in the same cycle leaves at least one entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        (do_insert && !cfg_write) |=> (fill_reg != '0))
        else $error("tpc_datapath: empty after insert");
`endif

endmodule

[hw/rtl/transpose_priority_cache.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transpose_priority_cache
// Ordered key/value cache with insert at front, tail eviction, and
// transposition of repeatedly hit entries toward the front.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  s_*       in         s_valid / s_ready      op, key, value_in, position
//  m_*       out        m_valid / m_ready      found, value_out, key_out
//  cfg_*     in         cfg_valid / cfg_ready  capacity_in_use
//
//  Each transaction has a compare step for the parallel key compare across the
//  entry row, then an update step for the priority pick, entry update and result.
//  Result appears in m_* the cycle after the update step.
//  Reset (aresetn low, synchronous) empties the cache, sets capacity to the
//  table size (at most 16) and clears the last hit key.
//  A stalled result holds the update step; a new transaction is still taken
//  in the idle state while an earlier result waits. Configuration is always ready.
// ----------------------------------------------------------------------------
module transpose_priority_cache
    import tpc_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [OP_W-1:0]   s_op,
    input  logic [KEY_W-1:0]  s_key,
    input  logic [VAL_W-1:0]  s_value_in,
    input  logic [POS_W-1:0]  s_position,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_found,
    output logic [VAL_W-1:0]  m_value_out,
    output logic [KEY_W-1:0]  m_key_out,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CAP_W-1:0]  cfg_capacity_in_use
);

    tpc_cmd_t cmd;

    // Capacity writes are taken at once
    assign cfg_ready = 1'b1;

    // Sequencer
    tpc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Entry storage and compare logic
    tpc_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .s_op                (s_op),
        .s_key               (s_key),
        .s_value_in          (s_value_in),
        .s_position          (s_position),
        .cfg_write           (cfg_valid && cfg_ready),
        .cfg_capacity_in_use (cfg_capacity_in_use),
        .m_found             (m_found),
        .m_value_out         (m_value_out),
        .m_key_out           (m_key_out)
    );

endmodule
